@@ rtl/core/gcd_pkg.sv @@
// ----------------------------------------------------------------------------
// gcd_pkg
// shared constants, widths and the cordic arctangent table for the
// great-circle distance filter
// ----------------------------------------------------------------------------
package gcd_pkg;

  // default cordic depth
  localparam int unsigned CordicStagesDef = 24;
  // digit steps of the square root
  localparam int unsigned SqrtSteps = 32;

  // datapath widths
  localparam int unsigned CW  = 34;  // cordic x, y, z
  localparam int unsigned SQW = 64;  // square root remainder and root
  localparam int unsigned TW  = 36;  // angle before wrapping
  localparam int unsigned MW  = 29;  // angle magnitude into the multiplier

  // configuration register indexes
  localparam logic [1:0] CfgTargetLat  = 2'd0;
  localparam logic [1:0] CfgTargetLon  = 2'd1;
  localparam logic [1:0] CfgMaxDist    = 2'd2;

  localparam logic [24:0] MaxDistReset = 25'd10240;

  // degree units to q30 radians, scaled by 2^24
  localparam logic [MW-1:0] DegToRadK = 29'd299845282;

  localparam logic signed [TW-1:0] Q30Pi     = 36'sd3373259426;
  localparam logic signed [TW-1:0] Q30HalfPi = 36'sd1686629713;
  localparam logic signed [TW-1:0] Q30TwoPi  = 36'sd6746518852;
  localparam logic signed [CW-1:0] InvGain   = 34'sd652032874;
  localparam logic signed [34:0]   Q30One    = 35'sd1073741824;

  localparam logic signed [31:0] LatLimit = 32'sd94371840;
  localparam logic signed [31:0] LonLimit = 32'sd188743680;

  localparam logic [12:0] EarthRadiusKm = 13'd6371;

  // arctangent of 2^-i in q30
  function automatic logic signed [CW-1:0] atan_step(input int unsigned i);
    logic signed [CW-1:0] v;
    case (i)
      0:  v = 34'sd843314857;
      1:  v = 34'sd497837829;
      2:  v = 34'sd263043837;
      3:  v = 34'sd133525159;
      4:  v = 34'sd67021687;
      5:  v = 34'sd33543516;
      6:  v = 34'sd16775851;
      7:  v = 34'sd8388437;
      8:  v = 34'sd4194283;
      9:  v = 34'sd2097149;
      10: v = 34'sd1048576;
      11: v = 34'sd524288;
      default: begin
        if (i <= 30) v = CW'(64'sd1 <<< (30 - i));
        else v = '0;
      end
    endcase
    return v;
  endfunction

endpackage

@@ rtl/core/great_circle_distance_filter_unit.sv @@
// ----------------------------------------------------------------------------
// great_circle_distance_filter_unit
// throughput: one word per cycle while no result word is held, set by the chain
// of cordic and root cells that every word walks through at one cell per cycle
// reset: control and config registers clear at once, max distance to 10 km
// ----------------------------------------------------------------------------
module great_circle_distance_filter_unit #(
  parameter int unsigned CORDIC_STAGES = gcd_pkg::CordicStagesDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // configuration
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [28:0]        cfg_wdata_i,
  // input words
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [31:0] doc_lat_i,
  input  logic signed [31:0] doc_lon_i,
  input  logic               lat_present_i,
  input  logic               lon_present_i,
  // result words
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               within_range_o
);

  localparam int unsigned N     = CORDIC_STAGES;
  localparam int unsigned NS    = gcd_pkg::SqrtSteps;
  localparam int unsigned CW    = gcd_pkg::CW;
  localparam int unsigned SQW   = gcd_pkg::SQW;
  localparam int unsigned TW    = gcd_pkg::TW;
  localparam int unsigned MW    = gcd_pkg::MW;
  // stage map: angle prep 0..3, rotation cells, three product stages,
  // root cells, vectoring cells, distance product
  localparam int unsigned Depth = 2 * N + NS + 8;
  localparam int unsigned Last  = Depth - 1;

  // --------------------------------------------------------------------------
  // configuration registers
  // --------------------------------------------------------------------------
  logic signed [27:0] tgt_lat_q;
  logic signed [28:0] tgt_lon_q;
  logic [24:0]        max_dist_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tgt_lat_q  <= '0;
      tgt_lon_q  <= '0;
      max_dist_q <= gcd_pkg::MaxDistReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        gcd_pkg::CfgTargetLat: tgt_lat_q  <= cfg_wdata_i[27:0];
        gcd_pkg::CfgTargetLon: tgt_lon_q  <= cfg_wdata_i;
        gcd_pkg::CfgMaxDist:   max_dist_q <= cfg_wdata_i[24:0];
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // flow control: the whole chain advances unless a finished word is held
  // --------------------------------------------------------------------------
  logic en;
  logic out_valid_q, within_q;
  logic vld_q [Depth];
  logic ok_q  [Depth];

  assign en         = !out_valid_q || !out_stall_i;
  assign in_stall_o = !en;

  // --------------------------------------------------------------------------
  // stage 0: range checks, angle differences and magnitudes
  // lanes: 0 dlat, 1 dlon, 2 doc lat, 3 target lat
  // --------------------------------------------------------------------------
  logic            ok_d;
  logic signed [33:0] ang_s [4];
  logic [MW-1:0]   mag_d [4];
  logic [MW-1:0]   mag_q [4];
  logic [3:0]      sgn_d, sgn0_q, sgn1_q, sgn2_q;

  always_comb begin
    ok_d = lat_present_i && lon_present_i &&
           doc_lat_i >= -gcd_pkg::LatLimit && doc_lat_i <= gcd_pkg::LatLimit &&
           doc_lon_i >= -gcd_pkg::LonLimit && doc_lon_i <= gcd_pkg::LonLimit;
    ang_s[0] = 34'(tgt_lat_q) - 34'(doc_lat_i);
    ang_s[1] = 34'(tgt_lon_q) - 34'(doc_lon_i);
    ang_s[2] = 34'(doc_lat_i);
    ang_s[3] = 34'(tgt_lat_q);
    for (int l = 0; l < 4; l++) begin
      // magnitudes fit 29 bits whenever the checks pass
      sgn_d[l] = ang_s[l][33];
      mag_d[l] = sgn_d[l] ? MW'(-ang_s[l]) : MW'(ang_s[l]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      mag_q  <= mag_d;
      sgn0_q <= sgn_d;
    end
  end

  // stage 1: scale to radians
  logic [2*MW-1:0] prod_q [4];

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int l = 0; l < 4; l++) prod_q[l] <= mag_q[l] * gcd_pkg::DegToRadK;
      sgn1_q <= sgn0_q;
    end
  end

  // stage 2: round half up, half angles for the differences, sign back
  logic signed [TW-1:0] th_d [4];
  logic signed [TW-1:0] th_q [4];
  logic [2*MW:0]        rnd;

  always_comb begin
    for (int l = 0; l < 4; l++) begin
      if (l < 2) rnd = ((2*MW+1)'(prod_q[l]) + (2*MW+1)'(1 << 24)) >> 25;
      else       rnd = ((2*MW+1)'(prod_q[l]) + (2*MW+1)'(1 << 23)) >> 24;
      th_d[l] = sgn1_q[l] ? -TW'(rnd) : TW'(rnd);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      th_q   <= th_d;
      sgn2_q <= sgn1_q;
    end
  end

  // stage 3: wrap into (-pi, pi], fold into [-pi/2, pi/2]
  logic signed [TW-1:0] w;
  logic signed [CW-1:0] z_d [4];
  logic signed [CW-1:0] z_q [4];
  logic [3:0]           neg_d, neg_q;

  always_comb begin
    for (int l = 0; l < 4; l++) begin
      w = th_q[l];
      if (w > gcd_pkg::Q30Pi)   w = w - gcd_pkg::Q30TwoPi;
      if (w > gcd_pkg::Q30Pi)   w = w - gcd_pkg::Q30TwoPi;
      if (w <= -gcd_pkg::Q30Pi) w = w + gcd_pkg::Q30TwoPi;
      if (w <= -gcd_pkg::Q30Pi) w = w + gcd_pkg::Q30TwoPi;
      neg_d[l] = 1'b0;
      if (w > gcd_pkg::Q30HalfPi) begin
        w = gcd_pkg::Q30Pi - w;
        neg_d[l] = 1'b1;
      end else if (w < -gcd_pkg::Q30HalfPi) begin
        w = -gcd_pkg::Q30Pi - w;
        neg_d[l] = 1'b1;
      end
      z_d[l] = CW'(w);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      z_q   <= z_d;
      neg_q <= neg_d;
    end
  end

  // --------------------------------------------------------------------------
  // rotation chains: sine of the half differences, cosine of both latitudes
  // --------------------------------------------------------------------------
  logic signed [CW-1:0] rx [4][N+1];
  logic signed [CW-1:0] ry [4][N+1];
  logic signed [CW-1:0] rz [4][N+1];
  logic [1:0]           negd_q [N];

  for (genvar l = 0; l < 4; l++) begin : g_rot_lane
    assign rx[l][0] = gcd_pkg::InvGain;
    assign ry[l][0] = '0;
    assign rz[l][0] = z_q[l];
    for (genvar j = 0; j < N; j++) begin : g_rot_cell
      gcd_cordic_cell #(.STEP(j), .VECTOR(1'b0)) u_cell (
        .clk_i (clk_i),
        .en_i  (en),
        .x_i   (rx[l][j]),
        .y_i   (ry[l][j]),
        .z_i   (rz[l][j]),
        .x_o   (rx[l][j+1]),
        .y_o   (ry[l][j+1]),
        .z_o   (rz[l][j+1])
      );
    end
  end

  // fold flags of the cosine lanes ride along the rotation chain
  always_ff @(posedge clk_i) begin
    if (en) begin
      negd_q[0] <= neg_q[3:2];
      for (int j = 1; j < N; j++) negd_q[j] <= negd_q[j-1];
    end
  end

  // --------------------------------------------------------------------------
  // haversine term a
  // --------------------------------------------------------------------------
  logic signed [31:0] s1, s2, c1, c2;
  logic signed [63:0] p_ss1, p_ss2, p_cc, p_t;
  logic signed [33:0] ss1_q, ss2_q, cc_q, ss1b_q, t_q;
  logic signed [34:0] a_sum;
  logic [30:0]        a_q;

  assign s1 = 32'(ry[0][N]);
  assign s2 = 32'(ry[1][N]);
  assign c1 = negd_q[N-1][0] ? -32'(rx[2][N]) : 32'(rx[2][N]);
  assign c2 = negd_q[N-1][1] ? -32'(rx[3][N]) : 32'(rx[3][N]);

  assign p_ss1 = s1 * s1;
  assign p_ss2 = s2 * s2;
  assign p_cc  = c1 * c2;
  assign p_t   = 32'(ss2_q) * 32'(cc_q);

  always_comb begin
    a_sum = 35'(ss1b_q) + 35'(t_q);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ss1_q  <= p_ss1[63:30];
      ss2_q  <= p_ss2[63:30];
      cc_q   <= p_cc[63:30];
      ss1b_q <= ss1_q;
      t_q    <= p_t[63:30];
      // clamp a into [0, 1]
      if (a_sum < 0)                   a_q <= '0;
      else if (a_sum > gcd_pkg::Q30One) a_q <= 31'(gcd_pkg::Q30One);
      else                             a_q <= a_sum[30:0];
    end
  end

  // --------------------------------------------------------------------------
  // root chains: lane 0 sqrt(a), lane 1 sqrt(1 - a)
  // --------------------------------------------------------------------------
  logic [SQW-1:0] sn [2][NS+1];
  logic [SQW-1:0] sr [2][NS+1];

  assign sn[0][0] = SQW'(a_q) << 30;
  assign sn[1][0] = SQW'(31'(gcd_pkg::Q30One) - a_q) << 30;
  assign sr[0][0] = '0;
  assign sr[1][0] = '0;

  for (genvar l = 0; l < 2; l++) begin : g_sqrt_lane
    for (genvar k = 0; k < NS; k++) begin : g_sqrt_cell
      gcd_sqrt_cell #(.STEP(k)) u_cell (
        .clk_i (clk_i),
        .en_i  (en),
        .n_i   (sn[l][k]),
        .r_i   (sr[l][k]),
        .n_o   (sn[l][k+1]),
        .r_o   (sr[l][k+1])
      );
    end
  end

  // --------------------------------------------------------------------------
  // vectoring chain: central half angle atan2(sqrt a, sqrt(1 - a))
  // --------------------------------------------------------------------------
  logic signed [CW-1:0] vx [N+1];
  logic signed [CW-1:0] vy [N+1];
  logic signed [CW-1:0] vz [N+1];

  assign vx[0] = CW'(sr[1][NS]);
  assign vy[0] = CW'(sr[0][NS]);
  assign vz[0] = '0;

  for (genvar j = 0; j < N; j++) begin : g_vec_cell
    gcd_cordic_cell #(.STEP(j), .VECTOR(1'b1)) u_cell (
      .clk_i (clk_i),
      .en_i  (en),
      .x_i   (vx[j]),
      .y_i   (vy[j]),
      .z_i   (vz[j]),
      .x_o   (vx[j+1]),
      .y_o   (vy[j+1]),
      .z_o   (vz[j+1])
    );
  end

  // --------------------------------------------------------------------------
  // distance in 1/1024 km and the limit compare
  // --------------------------------------------------------------------------
  logic [CW-1:0] ang;
  logic [46:0]   dprod_q;
  logic [26:0]   dist_units;

  assign ang        = (vz[N] < 0) ? '0 : CW'(vz[N]) << 1;
  assign dist_units = 27'((dprod_q + 47'(1 << 19)) >> 20);

  always_ff @(posedge clk_i) begin
    if (en) dprod_q <= 47'(ang) * 47'(gcd_pkg::EarthRadiusKm);
  end

  // --------------------------------------------------------------------------
  // valid and check flags alongside the datapath
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < Depth; i++) vld_q[i] <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      vld_q[0] <= in_valid_i;
      for (int i = 1; i < Depth; i++) vld_q[i] <= vld_q[i-1];
      out_valid_q <= vld_q[Last];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ok_q[0] <= ok_d;
      for (int i = 1; i < Depth; i++) ok_q[i] <= ok_q[i-1];
      within_q <= ok_q[Last] && (dist_units <= 27'(max_dist_q));
    end
  end

  assign out_valid_o    = out_valid_q;
  assign within_range_o = within_q;

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  a_accept_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> vld_q[0])
    else $error("accepted word did not enter the chain");

  a_hold_backs_up: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |-> in_stall_o)
    else $error("input taken while result word held");

  a_frozen_chain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(vld_q[Last]) && out_valid_o)
    else $error("chain moved while frozen");

endmodule

@@ rtl/core/gcd_cordic_cell.sv @@
// ----------------------------------------------------------------------------
// gcd_cordic_cell
// one registered cordic micro-rotation, rotation or vectoring mode
// ----------------------------------------------------------------------------
module gcd_cordic_cell #(
  parameter int unsigned STEP   = 0,
  parameter bit          VECTOR = 1'b0
) (
  input  logic                           clk_i,
  input  logic                           en_i,
  input  logic signed [gcd_pkg::CW-1:0]  x_i,
  input  logic signed [gcd_pkg::CW-1:0]  y_i,
  input  logic signed [gcd_pkg::CW-1:0]  z_i,
  output logic signed [gcd_pkg::CW-1:0]  x_o,
  output logic signed [gcd_pkg::CW-1:0]  y_o,
  output logic signed [gcd_pkg::CW-1:0]  z_o
);

  localparam logic signed [gcd_pkg::CW-1:0] At = gcd_pkg::atan_step(STEP);

  logic signed [gcd_pkg::CW-1:0] dx, dy;
  logic signed [gcd_pkg::CW-1:0] x_d, y_d, z_d;
  logic signed [gcd_pkg::CW-1:0] x_q, y_q, z_q;
  logic                          up;

  always_comb begin
    dx = y_i >>> STEP;
    dy = x_i >>> STEP;
    // rotation drives z to zero, vectoring drives y to zero
    up = VECTOR ? (y_i < 0) : (z_i >= 0);
    if (up) begin
      x_d = x_i - dx;
      y_d = y_i + dy;
      z_d = z_i - At;
    end else begin
      x_d = x_i + dx;
      y_d = y_i - dy;
      z_d = z_i + At;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q <= x_d;
      y_q <= y_d;
      z_q <= z_d;
    end
  end

  assign x_o = x_q;
  assign y_o = y_q;
  assign z_o = z_q;

endmodule

@@ rtl/core/gcd_sqrt_cell.sv @@
// ----------------------------------------------------------------------------
// gcd_sqrt_cell
// one registered step of the binary square root digit recurrence
// ----------------------------------------------------------------------------
module gcd_sqrt_cell #(
  parameter int unsigned STEP = 0
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic [gcd_pkg::SQW-1:0]  n_i,
  input  logic [gcd_pkg::SQW-1:0]  r_i,
  output logic [gcd_pkg::SQW-1:0]  n_o,
  output logic [gcd_pkg::SQW-1:0]  r_o
);

  localparam logic [gcd_pkg::SQW-1:0] Bit = gcd_pkg::SQW'(1) << (62 - 2 * STEP);

  logic [gcd_pkg::SQW-1:0] trial, n_d, r_d, n_q, r_q;

  always_comb begin
    trial = r_i + Bit;
    if (n_i >= trial) begin
      n_d = n_i - trial;
      r_d = (r_i >> 1) + Bit;
    end else begin
      n_d = n_i;
      r_d = r_i >> 1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      n_q <= n_d;
      r_q <= r_d;
    end
  end

  assign n_o = n_q;
  assign r_o = r_q;

endmodule
